/* rtl/stepper_ramp_profile_setup_assert.svh */
// assertion macros for the stepper ramp set-up block
// clocked on clk; the first form is disabled while rst is high
`ifndef STEPPER_RAMP_PROFILE_SETUP_ASSERT_SVH
`define STEPPER_RAMP_PROFILE_SETUP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRP_ASSERT(label, prop, msg)
`define SRP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* rtl/srp_pkg.sv */
// shared types, constants and helpers for the stepper ramp set-up block
// no dependencies
package srp_pkg;

  localparam int ROOT_FRAC_BITS = 8;
  localparam int WORD_W         = 32;
  localparam int ROOT_W         = 16 + ROOT_FRAC_BITS;
  localparam int REM_W          = (ROOT_W + 3 > WORD_W + 1) ? ROOT_W + 3 : WORD_W + 1;
  localparam int CNT_W          = $clog2(WORD_W + 1);
  localparam int RATE_W         = 15;
  localparam int STEP_W         = 16;
  localparam int DSTEP_W        = 17;
  localparam int RATE_SCALE     = 100;
  localparam int DELAY_SINGLE   = 1000;

  // floor(x / 100) for any 32-bit x is (x * DIV100_MAGIC) >> DIV100_SHIFT
  localparam logic [WORD_W-1:0] DIV100_MAGIC = 32'h51EB851F;
  localparam int                DIV100_SHIFT = 37;

  localparam logic [WORD_W-1:0] RST_ALPHA_FREQ  = 32'd196350;
  localparam logic [WORD_W-1:0] RST_FIRST_GAIN  = 32'd443023360;
  localparam logic [WORD_W-1:0] RST_ALPHA_TWICE = 32'd39269908;
  localparam logic [15:0]       RST_ALPHA_SCALE = 16'd39;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_SQRT} alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [WORD_W-1:0] opa;
    logic [WORD_W-1:0] opb;
  } alu_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOMOVE = 2'd1,
    STAT_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {RAMP_STOP, RAMP_ACCEL, RAMP_DECEL, RAMP_RUN} ramp_t;

  typedef enum logic [1:0] {
    REG_ALPHA_FREQ, REG_FIRST_GAIN, REG_ALPHA_TWICE, REG_ALPHA_SCALE
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MIN, S_Q, S_ROOT, S_PMUL, S_SDIV, S_DMUL, S_DDIV,
    S_VMUL, S_VDIV, S_SMUL, S_ADIV, S_AMUL, S_AMDIV, S_FIN, S_DONE
  } seq_state_t;

  function automatic logic [STEP_W-1:0] sat16(input logic [WORD_W-1:0] x);
    logic [STEP_W-1:0] r;
    r = (|x[WORD_W-1:STEP_W]) ? '1 : x[STEP_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/srp_alu.sv */
// shared arithmetic unit: registered multiply, bit-serial divide and root
// uses srp_pkg and the assertion macro header
`include "stepper_ramp_profile_setup_assert.svh"
module srp_alu (
  input  logic                      clk,
  input  logic                      rst,
  input  srp_pkg::alu_cmd_t         cmd,
  output logic                      done,
  output logic [srp_pkg::WORD_W-1:0] quo,
  output logic [2*srp_pkg::WORD_W-1:0] prod
);

  logic                               busy;
  srp_pkg::alu_op_t                   op_r;
  logic [srp_pkg::CNT_W-1:0]          cnt;
  logic [2*srp_pkg::WORD_W-1:0]       sh;
  logic [srp_pkg::REM_W-1:0]          rem;
  logic [srp_pkg::WORD_W-1:0]         res;
  logic [srp_pkg::WORD_W-1:0]         dvr;
  logic [srp_pkg::REM_W-1:0]          trial;
  logic [srp_pkg::REM_W-1:0]          sub;
  logic [srp_pkg::REM_W:0]            diff;
  logic                               ge;

  // one trial subtract serves both divide and root
  always_comb begin
    if (op_r == srp_pkg::OP_SQRT) begin
      trial = {rem[srp_pkg::REM_W-3:0], sh[2*srp_pkg::WORD_W-1 -: 2]};
      sub   = srp_pkg::REM_W'({res[srp_pkg::ROOT_W-1:0], 2'b01});
    end else begin
      trial = {rem[srp_pkg::REM_W-2:0], sh[2*srp_pkg::WORD_W-1]};
      sub   = srp_pkg::REM_W'(dvr);
    end
    diff = {1'b0, trial} - {1'b0, sub};
    ge   = ~diff[srp_pkg::REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_r <= srp_pkg::OP_DIV;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        op_r <= cmd.op;
        case (cmd.op)
          srp_pkg::OP_MUL: begin
            prod <= {{srp_pkg::WORD_W{1'b0}}, cmd.opa} * {{srp_pkg::WORD_W{1'b0}}, cmd.opb};
            done <= 1'b1;
          end
          srp_pkg::OP_SQRT: begin
            // radicand is opa shifted up by twice the fraction bits, taken msb first
            sh   <= {cmd.opa, {srp_pkg::WORD_W{1'b0}}};
            rem  <= '0;
            res  <= '0;
            cnt  <= srp_pkg::CNT_W'(srp_pkg::ROOT_W);
            busy <= 1'b1;
          end
          default: begin
            sh   <= {cmd.opa, {srp_pkg::WORD_W{1'b0}}};
            rem  <= '0;
            res  <= '0;
            dvr  <= cmd.opb;
            cnt  <= srp_pkg::CNT_W'(srp_pkg::WORD_W);
            busy <= 1'b1;
          end
        endcase
      end else if (busy) begin
        rem <= ge ? diff[srp_pkg::REM_W-1:0] : trial;
        res <= {res[srp_pkg::WORD_W-2:0], ge};
        sh  <= (op_r == srp_pkg::OP_SQRT) ? {sh[2*srp_pkg::WORD_W-3:0], 2'b00}
                                          : {sh[2*srp_pkg::WORD_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == srp_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = res;

  `SRP_ASSERT(a_start_idle, cmd.start |-> !busy, "alu started while busy")
  `SRP_ASSERT(a_busy_count, busy |-> cnt != '0, "alu busy with empty count")
  `SRP_ASSERT(a_done_pulse, done |=> !done, "alu done held for two cycles")

endmodule

/* rtl/stepper_ramp_profile_setup.sv */
// top level: command sequencer, config registers and held ramp record
// uses srp_pkg, srp_alu and the assertion macro header
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+-------------------
//   config   | cfg_we, cfg_index, cfg_data               | write on cfg_we
//   command  | step_count, accel_rate, decel_rate, top.. | in_valid/in_ready
//   record   | status, floor_delay .. ramp_state         | out_valid/out_ready
//
// a full ramp command runs five 32-bit divides, one 24-bit root and seven
// multiplies (the two scalings by 1/100 included), then a finish step and the
// output load; the velocity-squared multiply and its divide are skipped when
// the ramp-length divisor is zero
// zero-step, single-step and rejected commands skip the alu steps
// in_ready is high only while the sequencer is idle; a finished word stalls the
// sequencer while the previous word still waits for out_ready
// synchronous reset restores the default config, clears the held record and out_valid
`include "stepper_ramp_profile_setup_assert.svh"
module stepper_ramp_profile_setup (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        step_count,
  input  logic [7:0]         accel_rate,
  input  logic [7:0]         decel_rate,
  input  logic [7:0]         top_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [31:0]        floor_delay,
  output logic [31:0]        first_delay,
  output logic signed [16:0] decel_steps,
  output logic [15:0]        brake_start,
  output logic signed [0:0]  ramp_count,
  output logic [1:0]         ramp_state
);

  localparam int RW = srp_pkg::RATE_W;
  localparam int SW = srp_pkg::STEP_W;
  localparam int WW = srp_pkg::WORD_W;
  localparam int DW = srp_pkg::DSTEP_W;

  srp_pkg::seq_state_t state, state_next;
  srp_pkg::alu_cmd_t   cmd;
  logic                alu_done;
  logic [WW-1:0]       quo;
  logic [2*WW-1:0]     prod;
  logic [WW-1:0]       pct_q;

  logic [WW-1:0] alpha_freq, first_gain, alpha_twice;
  logic [15:0]   alpha_scale;

  logic          go;
  logic [SW-1:0] steps;
  logic [RW-1:0] ra, rd, rv;
  logic [WW-1:0] min_d, tmp, sd, dv;
  logic [SW-1:0] msl, al, tsat;
  srp_pkg::status_t stat;

  logic [WW-1:0]        held_floor_delay, held_first_delay;
  logic signed [DW-1:0] held_decel_steps;
  logic [SW-1:0]        held_brake_start;
  logic                 held_ramp_count;
  srp_pkg::ramp_t       held_ramp_state;

  logic [RW-1:0]        a_in, d_in, v_in;
  logic                 accept, rate_zero, is_op, out_load;
  logic signed [DW-1:0] ds_raw, ds;

  assign a_in = RW'(accel_rate) * RW'(srp_pkg::RATE_SCALE);
  assign d_in = RW'(decel_rate) * RW'(srp_pkg::RATE_SCALE);
  assign v_in = RW'(top_speed) * RW'(srp_pkg::RATE_SCALE);
  assign rate_zero = (accel_rate == 8'd0) || (decel_rate == 8'd0) || (top_speed == 8'd0);

  assign in_ready = (state == srp_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == srp_pkg::S_DONE) && (!out_valid || out_ready);

  // quotient by 100 from the reciprocal product
  assign pct_q = WW'(prod[2*WW-1:srp_pkg::DIV100_SHIFT]);

  // decel length: ramp-limited or speed-limited, never zero
  always_comb begin
    if (al <= msl) begin
      ds_raw = $signed({1'b0, al}) - $signed({1'b0, steps});
    end else begin
      ds_raw = -$signed({1'b0, tsat});
    end
    ds = (ds_raw == '0) ? '1 : ds_raw;
  end

  srp_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .done (alu_done),
    .quo  (quo),
    .prod (prod)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srp_pkg::S_IDLE: begin
        if (accept) begin
          if (step_count == 16'd0 || step_count == 16'd1 || rate_zero) begin
            state_next = srp_pkg::S_DONE;
          end else begin
            state_next = srp_pkg::S_MIN;
          end
        end
      end
      srp_pkg::S_MIN:   if (alu_done) state_next = srp_pkg::S_Q;
      srp_pkg::S_Q:     if (alu_done) state_next = srp_pkg::S_ROOT;
      srp_pkg::S_ROOT:  if (alu_done) state_next = srp_pkg::S_PMUL;
      srp_pkg::S_PMUL:  if (alu_done) state_next = srp_pkg::S_SDIV;
      srp_pkg::S_SDIV:  if (alu_done) state_next = srp_pkg::S_DMUL;
      srp_pkg::S_DMUL:  if (alu_done) state_next = srp_pkg::S_DDIV;
      srp_pkg::S_DDIV: begin
        if (alu_done) begin
          state_next = (pct_q == '0) ? srp_pkg::S_SMUL : srp_pkg::S_VMUL;
        end
      end
      srp_pkg::S_VMUL:  if (alu_done) state_next = srp_pkg::S_VDIV;
      srp_pkg::S_VDIV:  if (alu_done) state_next = srp_pkg::S_SMUL;
      srp_pkg::S_SMUL:  if (alu_done) state_next = srp_pkg::S_ADIV;
      srp_pkg::S_ADIV:  if (alu_done) state_next = srp_pkg::S_AMUL;
      srp_pkg::S_AMUL:  if (alu_done) state_next = srp_pkg::S_AMDIV;
      srp_pkg::S_AMDIV: if (alu_done) state_next = srp_pkg::S_FIN;
      srp_pkg::S_FIN:   state_next = srp_pkg::S_DONE;
      srp_pkg::S_DONE:  if (out_load) state_next = srp_pkg::S_IDLE;
      default:          state_next = srp_pkg::S_IDLE;
    endcase
  end

  // alu command for each step
  always_comb begin
    is_op   = 1'b1;
    cmd.op  = srp_pkg::OP_DIV;
    cmd.opa = '0;
    cmd.opb = '0;
    case (state)
      srp_pkg::S_MIN:   begin cmd.opa = alpha_freq;  cmd.opb = WW'(rv); end
      srp_pkg::S_Q:     begin cmd.opa = alpha_twice; cmd.opb = WW'(ra); end
      srp_pkg::S_ROOT:  begin cmd.op = srp_pkg::OP_SQRT; cmd.opa = tmp; end
      srp_pkg::S_PMUL:  begin cmd.op = srp_pkg::OP_MUL; cmd.opa = first_gain; cmd.opb = tmp; end
      srp_pkg::S_SDIV: begin
        cmd.op  = srp_pkg::OP_MUL;
        cmd.opa = prod[16+srp_pkg::ROOT_FRAC_BITS +: WW];
        cmd.opb = srp_pkg::DIV100_MAGIC;
      end
      srp_pkg::S_DMUL: begin
        cmd.op  = srp_pkg::OP_MUL;
        cmd.opa = WW'(alpha_scale);
        cmd.opb = WW'(ra);
      end
      srp_pkg::S_DDIV: begin
        cmd.op  = srp_pkg::OP_MUL;
        cmd.opa = prod[WW-1:0];
        cmd.opb = srp_pkg::DIV100_MAGIC;
      end
      srp_pkg::S_VMUL:  begin cmd.op = srp_pkg::OP_MUL; cmd.opa = WW'(rv); cmd.opb = WW'(rv); end
      srp_pkg::S_VDIV:  begin cmd.opa = prod[WW-1:0]; cmd.opb = dv; end
      srp_pkg::S_SMUL:  begin cmd.op = srp_pkg::OP_MUL; cmd.opa = WW'(steps); cmd.opb = WW'(rd); end
      srp_pkg::S_ADIV:  begin cmd.opa = prod[WW-1:0]; cmd.opb = WW'(ra) + WW'(rd); end
      srp_pkg::S_AMUL:  begin cmd.op = srp_pkg::OP_MUL; cmd.opa = WW'(msl); cmd.opb = WW'(ra); end
      srp_pkg::S_AMDIV: begin cmd.opa = prod[WW-1:0]; cmd.opb = WW'(rd); end
      default:          is_op = 1'b0;
    endcase
    cmd.start = is_op && !go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= srp_pkg::S_IDLE;
      go               <= 1'b0;
      out_valid        <= 1'b0;
      stat             <= srp_pkg::STAT_OK;
      alpha_freq       <= srp_pkg::RST_ALPHA_FREQ;
      first_gain       <= srp_pkg::RST_FIRST_GAIN;
      alpha_twice      <= srp_pkg::RST_ALPHA_TWICE;
      alpha_scale      <= srp_pkg::RST_ALPHA_SCALE;
      held_floor_delay <= '0;
      held_first_delay <= '0;
      held_decel_steps <= '0;
      held_brake_start <= '0;
      held_ramp_count  <= 1'b0;
      held_ramp_state  <= srp_pkg::RAMP_STOP;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          srp_pkg::REG_ALPHA_FREQ:  alpha_freq  <= cfg_data;
          srp_pkg::REG_FIRST_GAIN:  first_gain  <= cfg_data;
          srp_pkg::REG_ALPHA_TWICE: alpha_twice <= cfg_data;
          srp_pkg::REG_ALPHA_SCALE: alpha_scale <= cfg_data[15:0];
          default:                  alpha_freq  <= alpha_freq;
        endcase
      end

      if (cmd.start) begin
        go <= 1'b1;
      end else if (alu_done) begin
        go <= 1'b0;
      end

      if (accept) begin
        steps <= step_count;
        ra    <= a_in;
        rd    <= d_in;
        rv    <= v_in;
        if (step_count == 16'd0) begin
          stat <= srp_pkg::STAT_NOMOVE;
        end else if (step_count == 16'd1) begin
          // single step goes straight to deceleration
          stat             <= srp_pkg::STAT_OK;
          held_ramp_count  <= 1'b1;
          held_ramp_state  <= srp_pkg::RAMP_DECEL;
          held_first_delay <= WW'(srp_pkg::DELAY_SINGLE);
        end else if (rate_zero) begin
          stat <= srp_pkg::STAT_REJECT;
        end else begin
          stat <= srp_pkg::STAT_OK;
        end
      end

      if (alu_done) begin
        case (state)
          srp_pkg::S_MIN:   min_d <= quo;
          srp_pkg::S_Q:     tmp   <= quo;
          srp_pkg::S_ROOT:  tmp   <= quo;
          srp_pkg::S_SDIV:  sd    <= pct_q;
          srp_pkg::S_DDIV: begin
            dv <= pct_q;
            if (pct_q == '0) msl <= '1;
          end
          srp_pkg::S_VDIV:  msl  <= (quo == '0) ? SW'(1) : srp_pkg::sat16(quo);
          srp_pkg::S_ADIV:  al   <= (quo == '0) ? SW'(1) : quo[SW-1:0];
          srp_pkg::S_AMDIV: tsat <= srp_pkg::sat16(quo);
          default:          tmp  <= tmp;
        endcase
      end

      if (state == srp_pkg::S_FIN) begin
        held_floor_delay <= min_d;
        held_decel_steps <= ds;
        held_brake_start <= steps + ds[SW-1:0];
        held_ramp_count  <= 1'b0;
        if (sd <= min_d) begin
          held_first_delay <= min_d;
          held_ramp_state  <= srp_pkg::RAMP_RUN;
        end else begin
          held_first_delay <= sd;
          held_ramp_state  <= srp_pkg::RAMP_ACCEL;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word register, payload only
  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= stat;
      floor_delay <= held_floor_delay;
      first_delay <= held_first_delay;
      decel_steps <= held_decel_steps;
      brake_start <= held_brake_start;
      ramp_count  <= held_ramp_count;
      ramp_state  <= held_ramp_state;
    end
  end

  `SRP_ASSERT(a_done_expected, alu_done |-> go, "alu finished with no step waiting")
  `SRP_ASSERT(a_zero_move,
    (accept && step_count == 16'd0) |=> state == srp_pkg::S_DONE,
    "zero-step command started a ramp")
  `SRP_ASSERT(a_ok_decel,
    (out_valid && status == srp_pkg::STAT_OK && ramp_state != srp_pkg::RAMP_DECEL)
      |-> decel_steps[16],
    "ramp word with non-negative decel count")
  `SRP_ASSERT_ALWAYS(a_ready_idle, rst |=> in_ready, "not ready after reset")

endmodule
